// ===== rtl/core/psp_pkg.sv =====
// Shared types, constants and the rank lookup for the pivot picker.
// No dependencies; used by psp_ctrl, psp_dpath and the top level.
package psp_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int CFG_W     = 11;
  localparam int VALUE_W   = 32;
  localparam int RANK_W    = 10;
  localparam int CMP_W     = (CFG_W > CNT_W) ?
                             ((CFG_W > RANK_W) ? CFG_W : RANK_W) :
                             ((CNT_W > RANK_W) ? CNT_W : RANK_W);
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_LIMIT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_OFFSET = 1'b1;

  localparam logic [CFG_W-1:0] ORDER_LIMIT_RST    = 11'd1024;
  localparam logic [CFG_W-1:0] COUNTER_OFFSET_RST = 11'd0;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] pivot_value;
    logic [RANK_W-1:0]         pivot_rank;
    logic                      rank_error;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OUTER,
    S_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_RANK,
    S_EMIT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // store the accepted value
    logic latch_set; // last item: capture n and the sort bound
    logic outer_rd;  // read position i, open a scan
    logic scan_rd;   // read position j
    logic swap_a;    // mem[min_pos] <= outer value
    logic swap_b;    // mem[i] <= running minimum, i++
    logic rank_rd;   // look up rank, read mem[k]
    logic emit;      // register the result, clear the set
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic bound_zero; // sort bound of the set being closed is zero
    logic scan_end;   // j reached n
    logic outer_more; // another outer pass follows this one
  } status_t;

  function automatic logic [RANK_W-1:0] low_steps(input logic [CNT_W-1:0] s);
    logic [RANK_W-1:0] k;
    if (s > 50)      k = RANK_W'(24);
    else if (s > 40) k = RANK_W'(16);
    else if (s > 30) k = RANK_W'(12);
    else if (s > 20) k = RANK_W'(10);
    else if (s > 10) k = RANK_W'(8);
    else             k = RANK_W'(s >> 1);
    return k;
  endfunction

  // Short table while n + 1 < 120, long table otherwise
  function automatic logic [RANK_W-1:0] pick_rank(input logic [CNT_W-1:0] s,
                                                  input logic [CNT_W-1:0] n);
    logic [RANK_W-1:0] k;
    if (n < 119) begin
      if (s > 500)      k = RANK_W'(60);
      else if (s > 100) k = RANK_W'(32);
      else              k = low_steps(s);
    end else begin
      if (s > 550)      k = RANK_W'(100);
      else if (s > 300) k = RANK_W'(46);
      else if (s > 200) k = RANK_W'(36);
      else if (s > 150) k = RANK_W'(34);
      else if (s > 100) k = RANK_W'(32);
      else              k = low_steps(s);
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/psp_ctrl.sv =====
// Sequencer for load, selection-sort passes, rank lookup and result.
// Depends on psp_pkg.
module psp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last,
  input  psp_pkg::status_t status,
  output psp_pkg::cmd_t    cmd,
  output logic             busy
);

  psp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      psp_pkg::S_IDLE: begin
        if (start && last) begin
          state_next = status.bound_zero ? psp_pkg::S_RANK : psp_pkg::S_OUTER;
        end
      end
      psp_pkg::S_OUTER: state_next = psp_pkg::S_SCAN;
      psp_pkg::S_SCAN: begin
        if (status.scan_end) begin
          state_next = psp_pkg::S_SWAP_A;
        end
      end
      psp_pkg::S_SWAP_A: state_next = psp_pkg::S_SWAP_B;
      psp_pkg::S_SWAP_B: begin
        state_next = status.outer_more ? psp_pkg::S_OUTER : psp_pkg::S_RANK;
      end
      psp_pkg::S_RANK: state_next = psp_pkg::S_EMIT;
      psp_pkg::S_EMIT: state_next = psp_pkg::S_IDLE;
      default:         state_next = psp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      psp_pkg::S_IDLE: begin
        busy          = 1'b0;
        cmd.load      = start;
        cmd.latch_set = start && last;
      end
      psp_pkg::S_OUTER:  cmd.outer_rd = 1'b1;
      psp_pkg::S_SCAN:   cmd.scan_rd  = !status.scan_end;
      psp_pkg::S_SWAP_A: cmd.swap_a   = 1'b1;
      psp_pkg::S_SWAP_B: cmd.swap_b   = 1'b1;
      psp_pkg::S_RANK:   cmd.rank_rd  = 1'b1;
      psp_pkg::S_EMIT:   cmd.emit     = 1'b1;
      default:           busy         = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/psp_dpath.sv =====
// Value store, sort counters, running-minimum compare and result register.
// Depends on psp_pkg; driven by psp_ctrl.
module psp_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  psp_pkg::cmd_t                   cmd,
  input  psp_pkg::in_item_t               item,
  input  logic                            cfg_we,
  input  logic [psp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psp_pkg::CFG_W-1:0]       cfg_data,
  output psp_pkg::status_t                status,
  output psp_pkg::result_t                result,
  output logic                            done
);

  localparam int AW = psp_pkg::ADDR_W;
  localparam int CW = psp_pkg::CNT_W;
  localparam int VW = psp_pkg::VALUE_W;
  localparam int KW = psp_pkg::RANK_W;
  localparam int MW = psp_pkg::CMP_W;

  logic signed [VW-1:0] mem [psp_pkg::MAX_ITEMS];

  logic [psp_pkg::CFG_W-1:0] order_limit, counter_offset;
  logic [CW-1:0] cnt, n, bound, i, j;
  logic [CW-1:0] n_new, bound_new;
  logic [psp_pkg::CFG_W-1:0] diff;
  logic signed [VW-1:0] rd_data, running_min, outer_val;
  logic [AW-1:0] rd_addr, min_pos, pend_pos;
  logic pend, pend_first;
  logic [KW-1:0] k, k_now;
  logic k_err;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic signed [VW-1:0] wr_data;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      order_limit    <= psp_pkg::ORDER_LIMIT_RST;
      counter_offset <= psp_pkg::COUNTER_OFFSET_RST;
    end else if (cfg_we) begin
      if (cfg_index == psp_pkg::CFG_ORDER_LIMIT)    order_limit    <= cfg_data;
      if (cfg_index == psp_pkg::CFG_COUNTER_OFFSET) counter_offset <= cfg_data;
    end
  end

  // set size and sort bound as of the closing item
  always_comb begin
    n_new     = (cnt < CW'(psp_pkg::MAX_ITEMS)) ? cnt + CW'(1) : cnt;
    diff      = (order_limit > counter_offset) ? order_limit - counter_offset : '0;
    bound_new = (MW'(diff) > MW'(n_new)) ? n_new : CW'(diff);
  end

  assign status.bound_zero = (bound_new == '0);
  assign status.scan_end   = (j == n);
  assign status.outer_more = ((i + CW'(1)) < bound);

  assign k_now = psp_pkg::pick_rank(bound, n);

  // read address select
  always_comb begin
    rd_addr = AW'(j);
    if (cmd.outer_rd)     rd_addr = AW'(i);
    else if (cmd.rank_rd) rd_addr = AW'(k_now);
  end

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(cnt);
    wr_data = item.value;
    if (cmd.load) begin
      wr_en = (cnt < CW'(psp_pkg::MAX_ITEMS));
    end else if (cmd.swap_a) begin
      wr_en   = 1'b1;
      wr_addr = min_pos;
      wr_data = outer_val;
    end else if (cmd.swap_b) begin
      wr_en   = 1'b1;
      wr_addr = AW'(i);
      wr_data = running_min;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else begin
      if (cmd.emit)      cnt <= '0;
      else if (cmd.load) cnt <= n_new;
      pend <= cmd.outer_rd || cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_set) begin
      n     <= n_new;
      bound <= bound_new;
      i     <= '0;
    end else if (cmd.swap_b) begin
      i <= i + CW'(1);
    end
    if (cmd.outer_rd)     j <= i + CW'(1);
    else if (cmd.scan_rd) j <= j + CW'(1);
    pend_first <= cmd.outer_rd;
    pend_pos   <= cmd.outer_rd ? AW'(i) : AW'(j);
    if (cmd.rank_rd) begin
      k     <= k_now;
      k_err <= (MW'(k_now) >= MW'(n));
    end
  end

  // running minimum; earliest position wins ties
  always_ff @(posedge clk) begin
    if (pend) begin
      if (pend_first) begin
        running_min <= rd_data;
        outer_val   <= rd_data;
        min_pos     <= pend_pos;
      end else if (rd_data < running_min) begin
        running_min <= rd_data;
        min_pos     <= pend_pos;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      result.pivot_value <= k_err ? '0 : rd_data;
      result.pivot_rank  <= k;
      result.rank_error  <= k_err;
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held two cycles");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.rank_error |-> result.pivot_value == '0)
    else $error("rank error with nonzero pivot");
  a_bound_le_n: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.latch_set) |-> bound <= n) else $error("sort bound above set size");
  a_minpos_range: assert property (@(posedge clk) disable iff (rst)
    cmd.swap_a |-> (CW'(min_pos) >= i) && (CW'(min_pos) < n))
    else $error("minimum position outside unsorted tail");
`endif

endmodule

// ===== rtl/core/partial_selection_pivot_picker.sv =====
// Throughput: one value per cycle while loading; busy stays high from the last item until
// the result is formed. After the last item the controller runs one selection-sort pass per
// position below the sort bound s (one store port, one read per cycle), then rank lookup, emit
// and the done pulse; s of 0 skips to the rank lookup. The receiver cannot stall the result.
// Reset (rst, synchronous): clears set count, controller and strobe; order_limit = 1024,
// counter_offset = 0. The value store is not cleared: only values written for the current set reach the result.
module partial_selection_pivot_picker (
  input  logic                            clk,
  input  logic                            rst,
  // input transactions: accepted when start && !busy
  input  logic                            start,
  input  psp_pkg::in_item_t               item,
  output logic                            busy,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [psp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psp_pkg::CFG_W-1:0]       cfg_data,
  // result transactions: valid for the single cycle done is high
  output psp_pkg::result_t                result,
  output logic                            done
);

  psp_pkg::cmd_t    cmd;
  psp_pkg::status_t status;

  // FSM: idle/load, per-pass outer read, scan, swap A and swap B writes, rank read, emit
  psp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (item.last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Store, counters, min tracker; the result register lets a new set start loading
  // in the cycle the strobe is shown.
  psp_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result),
    .done      (done)
  );

endmodule
